// ===== rtl/core/asmt_pkg.sv =====
// shared types and constants for the alignment score and mismatch tag block
`timescale 1ns / 1ps
package asmt_pkg;

  // element codes on the input channel
  typedef enum logic [1:0] {
    CMD_ALIGNED = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_END     = 2'd3
  } cmd_e;

  // record codes on the output channel
  typedef enum logic [1:0] {
    KIND_MISMATCH  = 2'd0,
    KIND_DEL_START = 2'd1,
    KIND_DEL_CONT  = 2'd2,
    KIND_TOTALS    = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic [2:0] REG_MM_MAX      = 3'd0;
  localparam logic [2:0] REG_MM_MIN      = 3'd1;
  localparam logic [2:0] REG_UNKNOWN     = 3'd2;
  localparam logic [2:0] REG_READ_OPEN   = 3'd3;
  localparam logic [2:0] REG_READ_EXTEND = 3'd4;
  localparam logic [2:0] REG_REF_OPEN    = 3'd5;
  localparam logic [2:0] REG_REF_EXTEND  = 3'd6;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned QUAL_W  = 7;
  localparam int unsigned PROD_W  = CFG_W + QUAL_W;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned SCORE_W = 18;
  localparam int unsigned CHG_W   = 7;

  localparam logic [7:0] CH_N       = 8'd78;
  localparam logic [7:0] PHRED_BASE = 8'd33;
  localparam logic [CNT_W-1:0] FIELD11_MAX = '1;
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // penalty register file
  typedef struct packed {
    logic [CFG_W-1:0] mm_max;
    logic [CFG_W-1:0] mm_min;
    logic [CFG_W-1:0] unknown;
    logic [CFG_W-1:0] read_open;
    logic [CFG_W-1:0] read_extend;
    logic [CFG_W-1:0] ref_open;
    logic [CFG_W-1:0] ref_extend;
  } cfg_t;

  // classified element held in the queue
  typedef struct packed {
    cmd_e              cmd;
    logic              mismatch;
    logic              any_n;
    logic              ref_n;
    logic              opens;
    logic              has_result;
    logic [PROD_W-1:0] prod;
    logic [7:0]        ref_base;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/asmt_in_if.sv =====
// input channel carrying one alignment element per transaction
`timescale 1ns / 1ps
interface asmt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] read_base;
  logic [7:0] ref_base;
  logic [7:0] quality;
  logic       opens_gap;

  modport source (output valid, cmd, read_base, ref_base, quality, opens_gap,
                  input ready);
  modport sink (input valid, cmd, read_base, ref_base, quality, opens_gap,
                output ready);
endinterface

// ===== rtl/core/asmt_out_if.sv =====
// output channel carrying one md record or read totals per transaction
`timescale 1ns / 1ps
interface asmt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [10:0]        run_length;
  logic [7:0]         md_base;
  logic signed [17:0] score;
  logic [10:0]        mismatches;
  logic [10:0]        gap_opens;
  logic [10:0]        gap_extends;
  logic [11:0]        edit_distance;

  modport source (output valid, kind, run_length, md_base, score, mismatches,
                  gap_opens, gap_extends, edit_distance, input ready);
  modport sink (input valid, kind, run_length, md_base, score, mismatches,
                gap_opens, gap_extends, edit_distance, output ready);
endinterface

// ===== rtl/core/asmt_front.sv =====
// front end: accepts elements, compares bases and forms the quality product
`timescale 1ns / 1ps
module asmt_front
  import asmt_pkg::*;
#(
  parameter int unsigned QUAL_CAP = 40
) (
  asmt_in_if.sink item_i,
  input  cfg_t    cfg_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output entry_t  entry_o
);

  localparam logic [QUAL_W-1:0] QCAP = QUAL_W'(QUAL_CAP);

  logic [7:0]        q_raw;
  logic [QUAL_W-1:0] q_clamp;
  logic [CFG_W-1:0]  diff;
  logic              mism;
  logic              any_n;
  cmd_e              cmd;

  // handshake: take a transaction whenever the queue has room
  assign item_i.ready = !q_stat_i.full;
  assign push_o       = item_i.valid && !q_stat_i.full;

  // quality offset removal and cap
  always_comb begin
    q_raw = (item_i.quality > PHRED_BASE) ? (item_i.quality - PHRED_BASE) : 8'd0;
    if (q_raw > {1'b0, QCAP}) begin
      q_clamp = QCAP;
    end else begin
      q_clamp = q_raw[QUAL_W-1:0];
    end
  end

  // penalty span, zero when min is above max
  assign diff = (cfg_i.mm_max > cfg_i.mm_min) ? (cfg_i.mm_max - cfg_i.mm_min) : '0;

  assign cmd   = cmd_e'(item_i.cmd);
  assign mism  = item_i.read_base != item_i.ref_base;
  assign any_n = (item_i.read_base == CH_N) || (item_i.ref_base == CH_N);

  // classify the element
  always_comb begin
    entry_o.cmd        = cmd;
    entry_o.mismatch   = mism;
    entry_o.any_n      = any_n;
    entry_o.ref_n      = item_i.ref_base == CH_N;
    entry_o.opens      = item_i.opens_gap;
    entry_o.prod       = PROD_W'(diff) * PROD_W'(q_clamp);
    entry_o.ref_base   = item_i.ref_base;
    case (cmd)
      CMD_ALIGNED: entry_o.has_result = mism;
      CMD_INSERT:  entry_o.has_result = 1'b0;
      default:     entry_o.has_result = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/asmt_queue.sv =====
// two-entry queue between the front end and the scoring back end
`timescale 1ns / 1ps
module asmt_queue
  import asmt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  entry_i,
  input  logic    pop_i,
  output entry_t  entry_o,
  output q_stat_t q_stat_o
);

  logic [1:0] count_q, count_d;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  entry_t     mem_q [2];

  assign q_stat_o.full  = count_q == 2'd2;
  assign q_stat_o.empty = count_q == 2'd0;
  assign entry_o        = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/asmt_back.sv =====
// back end: applies penalties, updates counters and registers results
`timescale 1ns / 1ps
module asmt_back
  import asmt_pkg::*;
#(
  parameter int unsigned MAX_READ_LEN = 1024,
  parameter int unsigned QUAL_CAP     = 40
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  entry_t  entry_i,
  input  q_stat_t q_stat_i,
  output logic    pop_o,
  asmt_out_if.source result_o
);

  localparam logic [CNT_W-1:0] CNT_CAP =
    (MAX_READ_LEN > 2047) ? FIELD11_MAX : CNT_W'(MAX_READ_LEN);
  localparam int unsigned RSH = 20;
  localparam int unsigned RECIP_W = RSH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RSH) + QUAL_CAP - 1) / QUAL_CAP);
  localparam int unsigned MUL_W = PROD_W + RECIP_W;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    bump = (v < CNT_CAP) ? (v + 1'b1) : CNT_CAP;
  endfunction

  logic signed [SCORE_W-1:0] score_q, score_d;
  logic [CNT_W-1:0]          mm_q, mm_d;
  logic [CNT_W-1:0]          go_q, go_d;
  logic [CNT_W-1:0]          ge_q, ge_d;
  logic [CNT_W-1:0]          run_q, run_d;
  logic                      in_del_q, in_del_d;

  logic                      out_valid_q;
  kind_e                     kind_q, kind_d;
  logic [CNT_W-1:0]          run_len_q, run_len_d;
  logic [7:0]                md_base_q, md_base_d;
  logic [SCORE_W-1:0]        tot_score_q, tot_score_d;
  logic [CNT_W-1:0]          tot_mm_q, tot_mm_d;
  logic [CNT_W-1:0]          tot_go_q, tot_go_d;
  logic [CNT_W-1:0]          tot_ge_q, tot_ge_d;
  logic [CNT_W:0]            tot_ed_q, tot_ed_d;

  logic [MUL_W-1:0]          scaled;
  logic [CFG_W-1:0]          quot;
  logic [CHG_W-1:0]          mm_pen;
  logic [CHG_W-1:0]          charge;
  logic [SCORE_W:0]          diff;
  logic                      del_start;
  logic                      out_free;

  // handshake: items without a record never wait on the output register
  assign out_free = !out_valid_q || result_o.ready;
  assign pop_o    = !q_stat_i.empty && (!entry_i.has_result || out_free);

  // scaled mismatch penalty, division by the cap through a reciprocal
  assign scaled = MUL_W'(entry_i.prod) * MUL_W'(RECIP);
  assign quot   = scaled[RSH +: CFG_W];
  assign mm_pen = entry_i.any_n ? CHG_W'(cfg_i.unknown)
                                : (CHG_W'(cfg_i.mm_min) + CHG_W'(quot));

  assign del_start = entry_i.opens || !in_del_q;

  // total charge for this element
  always_comb begin
    case (entry_i.cmd)
      CMD_ALIGNED: begin
        if (entry_i.mismatch) begin
          charge = mm_pen;
        end else if (entry_i.ref_n) begin
          charge = CHG_W'(cfg_i.unknown);
        end else begin
          charge = '0;
        end
      end
      CMD_INSERT:
        charge = (entry_i.opens ? CHG_W'(cfg_i.read_open) : '0) +
                 CHG_W'(cfg_i.read_extend);
      CMD_DELETE:
        charge = (del_start ? CHG_W'(cfg_i.ref_open) : '0) +
                 CHG_W'(cfg_i.ref_extend);
      default: charge = '0;
    endcase
  end

  // saturating score update, underflow when the result drops below the floor
  assign diff = {score_q[SCORE_W-1], score_q} - (SCORE_W+1)'(charge);

  always_comb begin
    if (diff[SCORE_W] && !diff[SCORE_W-1]) begin
      score_d = signed'(SCORE_MIN);
    end else begin
      score_d = signed'(diff[SCORE_W-1:0]);
    end
  end

  // counters and record contents
  always_comb begin
    mm_d        = mm_q;
    go_d        = go_q;
    ge_d        = ge_q;
    run_d       = run_q;
    in_del_d    = 1'b0;
    kind_d      = KIND_TOTALS;
    run_len_d   = run_q;
    md_base_d   = entry_i.ref_base;
    tot_score_d = '0;
    tot_mm_d    = '0;
    tot_go_d    = '0;
    tot_ge_d    = '0;
    tot_ed_d    = '0;
    case (entry_i.cmd)
      CMD_ALIGNED: begin
        kind_d = KIND_MISMATCH;
        if (entry_i.mismatch) begin
          mm_d  = bump(mm_q);
          run_d = '0;
        end else begin
          run_d = bump(run_q);
        end
      end
      CMD_INSERT: begin
        if (entry_i.opens) begin
          go_d = bump(go_q);
        end
        ge_d = bump(ge_q);
      end
      CMD_DELETE: begin
        in_del_d = 1'b1;
        ge_d     = bump(ge_q);
        if (del_start) begin
          kind_d = KIND_DEL_START;
          go_d   = bump(go_q);
          run_d  = '0;
        end else begin
          kind_d    = KIND_DEL_CONT;
          run_len_d = '0;
        end
      end
      default: begin
        md_base_d   = '0;
        tot_score_d = score_q;
        tot_mm_d    = mm_q;
        tot_go_d    = go_q;
        tot_ge_d    = ge_q;
        tot_ed_d    = (CNT_W+1)'(mm_q) + (CNT_W+1)'(ge_q);
      end
    endcase
  end

  // read state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q     <= '0;
      mm_q        <= '0;
      go_q        <= '0;
      ge_q        <= '0;
      run_q       <= '0;
      in_del_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (entry_i.cmd == CMD_END) begin
          score_q  <= '0;
          mm_q     <= '0;
          go_q     <= '0;
          ge_q     <= '0;
          run_q    <= '0;
          in_del_q <= 1'b0;
        end else begin
          score_q  <= score_d;
          mm_q     <= mm_d;
          go_q     <= go_d;
          ge_q     <= ge_d;
          run_q    <= run_d;
          in_del_q <= in_del_d;
        end
      end
      if (pop_o && entry_i.has_result) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // record payload
  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.has_result) begin
      kind_q      <= kind_d;
      run_len_q   <= run_len_d;
      md_base_q   <= md_base_d;
      tot_score_q <= tot_score_d;
      tot_mm_q    <= tot_mm_d;
      tot_go_q    <= tot_go_d;
      tot_ge_q    <= tot_ge_d;
      tot_ed_q    <= tot_ed_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.kind          = kind_q;
  assign result_o.run_length    = run_len_q;
  assign result_o.md_base       = md_base_q;
  assign result_o.score         = signed'(tot_score_q);
  assign result_o.mismatches    = tot_mm_q;
  assign result_o.gap_opens     = tot_go_q;
  assign result_o.gap_extends   = tot_ge_q;
  assign result_o.edit_distance = tot_ed_q;

endmodule

// ===== rtl/core/alignment_score_and_mismatch_tags.sv =====
// top level: alignment score and md record streamer
// Usage:
//   item_i carries one element of an aligned read per transaction: an aligned
//   base pair, an inserted read base, a deleted reference base or end of read.
//   result_o carries at most one record per element: a mismatch, a deletion
//   start or continuation base, or the read totals with the edit distance.
//   Penalty registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while no element is in flight; indexes past the last register are ignored.
// Timing:
//   one element per cycle sustained while no record is held back by the
//   receiver; a record passes through the queue and is then scored straight
//   into the output register, from which it is valid on result_o. The
//   scoring back end sets the rate: its score and counter update is
//   combinational from the queue head into the registered read state.
//   When the receiver stalls, the record holds in the output register and the
//   queue absorbs two more elements before item_i.ready drops; elements that
//   make no record keep flowing past a held record.
//   Reset clears the running totals, the queue and the output register and
//   loads the default penalties.
`timescale 1ns / 1ps
module alignment_score_and_mismatch_tags
  import asmt_pkg::*;
#(
  parameter int unsigned MAX_READ_LEN = 1024,
  parameter int unsigned QUAL_CAP     = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  asmt_in_if.sink          item_i,
  asmt_out_if.source       result_o
);

  cfg_t    cfg_q;
  entry_t  front_entry;
  entry_t  head_entry;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  // penalty registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mm_max      <= CFG_W'(6);
      cfg_q.mm_min      <= CFG_W'(2);
      cfg_q.unknown     <= CFG_W'(1);
      cfg_q.read_open   <= CFG_W'(5);
      cfg_q.read_extend <= CFG_W'(3);
      cfg_q.ref_open    <= CFG_W'(5);
      cfg_q.ref_extend  <= CFG_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MM_MAX:      cfg_q.mm_max      <= cfg_wdata_i;
        REG_MM_MIN:      cfg_q.mm_min      <= cfg_wdata_i;
        REG_UNKNOWN:     cfg_q.unknown     <= cfg_wdata_i;
        REG_READ_OPEN:   cfg_q.read_open   <= cfg_wdata_i;
        REG_READ_EXTEND: cfg_q.read_extend <= cfg_wdata_i;
        REG_REF_OPEN:    cfg_q.ref_open    <= cfg_wdata_i;
        REG_REF_EXTEND:  cfg_q.ref_extend  <= cfg_wdata_i;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  asmt_front #(
    .QUAL_CAP (QUAL_CAP)
  ) u_front (
    .item_i   (item_i),
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (front_entry)
  );

  asmt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .q_stat_o (q_stat)
  );

  asmt_back #(
    .MAX_READ_LEN (MAX_READ_LEN),
    .QUAL_CAP     (QUAL_CAP)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .entry_i  (head_entry),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .result_o (result_o)
  );

  // queue never reports full and empty together, never pops when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty))
    else $error("queue status inconsistent");

  // totals record carries a consistent edit distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.kind == KIND_TOTALS) |->
    (result_o.edit_distance == 12'(result_o.mismatches) + 12'(result_o.gap_extends)))
    else $error("edit distance mismatch");

  // the score never goes positive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.kind == KIND_TOTALS) |->
    (result_o.score[17] || result_o.score == '0))
    else $error("positive score");

  // a deletion continuation base never reports a run length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.kind == KIND_DEL_CONT) |-> result_o.run_length == '0)
    else $error("run length on deletion continuation");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the alignment score and md record streamer
`timescale 1ns / 1ps
module tb_top;
  import asmt_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CNT_CAP     = 1024;     // read length limit, fits the 11-bit fields
  localparam int          SCORE_FLOOR = -131072;
  localparam int unsigned QCAP        = 40;
  localparam int unsigned RAND_ITEMS  = 230;      // per idling phase
  localparam int unsigned LONG_LEN    = 1050;     // past the gap count ceilings and score floor
  localparam int unsigned TAIL_LEN    = 8;        // elements of each kind held at the limits
  localparam int unsigned SETTLE      = 6;        // margin for the queue and output register to empty
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PRINT_LIMIT = 100;
  localparam logic [2:0]  REG_SPARE   = 3'd7;     // past the last register, must be ignored
  localparam cfg_t        PEN_RESET   = {6'd6, 6'd2, 6'd1, 6'd5, 6'd3, 6'd5, 6'd3};

  // one md record or read totals
  typedef struct packed {
    kind_e              kind;
    logic [10:0]        run_length;
    logic [7:0]         md_base;
    logic signed [17:0] score;
    logic [10:0]        mismatches;
    logic [10:0]        gap_opens;
    logic [10:0]        gap_extends;
    logic [11:0]        edit_distance;
  } md_rec_t;

  // one alignment element, with an optional hand-written record
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] read_base;
    logic [7:0] ref_base;
    logic [7:0] quality;
    logic       opens_gap;
    logic       typed;
    logic       has_rec;
    md_rec_t    rec;
  } element_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [2:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  asmt_in_if  item_if ();
  asmt_out_if result_if ();

  alignment_score_and_mismatch_tags dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // scoring state mirrored from the block
  cfg_t        pen;
  int          score_acc;
  int unsigned mm_cnt;
  int unsigned gap_open_cnt;
  int unsigned gap_ext_cnt;
  int unsigned match_run;
  bit          in_del;

  md_rec_t     pending_records[$];
  element_t    directed_rows[$];
  int          err_count      = 0;
  int          elems_sent     = 0;
  int          records_seen   = 0;
  int          directed_count = 0;
  int          cycle_cnt      = 0;
  int unsigned gap_pct        = 0;
  int unsigned stall_pct      = 0;

  function automatic int unsigned sat_inc(input int unsigned v);
    return (v < CNT_CAP) ? v + 1 : CNT_CAP;
  endfunction

  // score only goes down and stops at the floor
  function automatic void charge(input int unsigned p);
    int s;
    s = score_acc - int'(p);
    score_acc = (s < SCORE_FLOOR) ? SCORE_FLOOR : s;
  endfunction

  function automatic void clear_read();
    score_acc    = 0;
    mm_cnt       = 0;
    gap_open_cnt = 0;
    gap_ext_cnt  = 0;
    match_run    = 0;
    in_del       = 1'b0;
  endfunction

  // predicted record, if any, for one accepted element
  function automatic bit score_element(input element_t e, output md_rec_t rec);
    int unsigned q;
    int unsigned d;
    int unsigned p;
    int unsigned sum;
    bit          starts;
    rec = '0;
    if (e.cmd != CMD_DELETE) in_del = 1'b0;
    case (e.cmd)
      CMD_ALIGNED: begin
        if (e.read_base != e.ref_base) begin
          mm_cnt = sat_inc(mm_cnt);
          if (e.read_base == CH_N || e.ref_base == CH_N) begin
            p = pen.unknown;
          end else begin
            q = (e.quality > PHRED_BASE) ? e.quality - PHRED_BASE : 0;
            if (q > QCAP) q = QCAP;
            d = (pen.mm_max > pen.mm_min) ? pen.mm_max - pen.mm_min : 0;
            p = pen.mm_min + d * q / QCAP;
          end
          charge(p);
          rec.kind       = KIND_MISMATCH;
          rec.run_length = match_run[10:0];
          rec.md_base    = e.ref_base;
          match_run      = 0;
          return 1'b1;
        end
        // a match against an unknown reference base still costs
        if (e.ref_base == CH_N) charge(pen.unknown);
        match_run = sat_inc(match_run);
        return 1'b0;
      end
      CMD_INSERT: begin
        if (e.opens_gap) begin
          charge(pen.read_open);
          gap_open_cnt = sat_inc(gap_open_cnt);
        end
        charge(pen.read_extend);
        gap_ext_cnt = sat_inc(gap_ext_cnt);
        return 1'b0;
      end
      CMD_DELETE: begin
        // a continuation with no open run starts one
        starts = e.opens_gap || !in_del;
        if (starts) begin
          charge(pen.ref_open);
          gap_open_cnt   = sat_inc(gap_open_cnt);
          rec.kind       = KIND_DEL_START;
          rec.run_length = match_run[10:0];
          match_run      = 0;
        end else begin
          rec.kind = KIND_DEL_CONT;
        end
        charge(pen.ref_extend);
        gap_ext_cnt = sat_inc(gap_ext_cnt);
        in_del      = 1'b1;
        rec.md_base = e.ref_base;
        return 1'b1;
      end
      default: begin
        sum                = mm_cnt + gap_ext_cnt;
        rec.kind           = KIND_TOTALS;
        rec.run_length     = match_run[10:0];
        rec.score          = score_acc[17:0];
        rec.mismatches     = mm_cnt[10:0];
        rec.gap_opens      = gap_open_cnt[10:0];
        rec.gap_extends    = gap_ext_cnt[10:0];
        rec.edit_distance  = sum[11:0];
        clear_read();
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, exp_v);
  endtask

  // compare one output transaction with the oldest pending record
  task automatic check_record();
    md_rec_t want;
    if (pending_records.size() == 0) begin
      report_mismatch("record with nothing pending, kind", result_if.kind, -1);
      return;
    end
    want = pending_records.pop_front();
    records_seen++;
    if (result_if.kind != want.kind)
      report_mismatch("kind", result_if.kind, want.kind);
    if (result_if.run_length != want.run_length)
      report_mismatch("run_length", result_if.run_length, want.run_length);
    if (result_if.md_base != want.md_base)
      report_mismatch("md_base", result_if.md_base, want.md_base);
    if (result_if.score != want.score)
      report_mismatch("score", result_if.score, want.score);
    if (result_if.mismatches != want.mismatches)
      report_mismatch("mismatches", result_if.mismatches, want.mismatches);
    if (result_if.gap_opens != want.gap_opens)
      report_mismatch("gap_opens", result_if.gap_opens, want.gap_opens);
    if (result_if.gap_extends != want.gap_extends)
      report_mismatch("gap_extends", result_if.gap_extends, want.gap_extends);
    if (result_if.edit_distance != want.edit_distance)
      report_mismatch("edit_distance", result_if.edit_distance, want.edit_distance);
  endtask

  // receiver: check on accept, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) check_record();
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records still pending", cycle_cnt,
               pending_records.size());
      $display("alignment_score_and_mismatch_tags test failed");
      $finish;
    end
  end

  // drive one element and hold it until the transaction completes
  task automatic send_element(input element_t e);
    md_rec_t rec;
    bit      has;
    while ($urandom_range(99) < gap_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.cmd       <= e.cmd;
    item_if.read_base <= e.read_base;
    item_if.ref_base  <= e.ref_base;
    item_if.quality   <= e.quality;
    item_if.opens_gap <= e.opens_gap;
    do @(posedge clk_i); while (!item_if.ready);
    elems_sent++;
    has = score_element(e, rec);
    if (e.typed) begin
      has = e.has_rec;
      rec = e.rec;
    end
    if (has) pending_records = {pending_records, rec};
  endtask

  // hold off until every record is back and the pipeline is empty
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write every penalty register, plus the unused index
  task automatic set_penalties(input cfg_t c);
    logic [CFG_W-1:0] vals [8];
    vals[REG_MM_MAX]      = c.mm_max;
    vals[REG_MM_MIN]      = c.mm_min;
    vals[REG_UNKNOWN]     = c.unknown;
    vals[REG_READ_OPEN]   = c.read_open;
    vals[REG_READ_EXTEND] = c.read_extend;
    vals[REG_REF_OPEN]    = c.ref_open;
    vals[REG_REF_EXTEND]  = c.ref_extend;
    vals[REG_SPARE]       = CFG_W'($urandom_range(63));
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[2:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    pen = c;
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(9))
      0, 1:    return "A";
      2, 3:    return "C";
      4, 5:    return "G";
      6, 7:    return "T";
      8:       return "N";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_quality();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(75, 33));
  endfunction

  task automatic add_row(input cmd_e c, input logic [7:0] rd, input logic [7:0] rf,
                         input logic [7:0] ql, input logic op, input logic typed,
                         input logic has, input kind_e k, input logic [10:0] run,
                         input logic [7:0] md);
    element_t e;
    e                = '0;
    e.cmd            = c;
    e.read_base      = rd;
    e.ref_base       = rf;
    e.quality        = ql;
    e.opens_gap      = op;
    e.typed          = typed;
    e.has_rec        = has;
    e.rec.kind       = k;
    e.rec.run_length = run;
    e.rec.md_base    = md;
    directed_rows    = {directed_rows, e};
  endtask

  // one read: mostly well-formed runs, some noise, sometimes no end marker
  task automatic send_random_read();
    element_t    e;
    int unsigned len;
    int unsigned run;
    int unsigned r;
    len = ($urandom_range(9) == 0) ? $urandom_range(120, 1) : $urandom_range(30, 1);
    for (int unsigned i = 0; i < len; i++) begin
      r           = $urandom_range(99);
      e           = '0;
      e.read_base = pick_base();
      e.ref_base  = pick_base();
      e.quality   = pick_quality();
      e.opens_gap = 1'($urandom_range(1));
      if (r < 55) begin
        e.cmd = CMD_ALIGNED;
        if ($urandom_range(3) != 0) e.ref_base = e.read_base;
        send_element(e);
      end else if (r < 90) begin
        e.cmd = (r < 72) ? CMD_INSERT : CMD_DELETE;
        run   = $urandom_range(4, 1);
        for (int unsigned k = 0; k < run; k++) begin
          // gap mark on the first base, now and then misplaced
          e.opens_gap = (k == 0) ^ ($urandom_range(9) == 0);
          e.read_base = pick_base();
          e.ref_base  = pick_base();
          send_element(e);
        end
      end else begin
        e.cmd       = cmd_e'($urandom_range(3));
        e.read_base = 8'($urandom_range(255));
        e.ref_base  = 8'($urandom_range(255));
        e.quality   = 8'($urandom_range(255));
        send_element(e);
      end
    end
    if ($urandom_range(19) != 0) begin
      e.cmd       = CMD_END;
      e.read_base = 8'($urandom_range(255));
      e.ref_base  = 8'($urandom_range(255));
      e.opens_gap = 1'($urandom_range(1));
      send_element(e);
    end
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = elems_sent + n_items;
    while (elems_sent < stop_at) begin
      send_random_read();
      if ($urandom_range(39) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // long read: opening insertions past the gap count ceilings and down to the
  // score floor, then a short tail of matches, mismatches and deletions held at those limits
  task automatic send_long_read();
    element_t e;
    e     = '0;
    e.cmd = CMD_END;
    send_element(e);
    e.cmd       = CMD_INSERT;
    e.opens_gap = 1'b1;
    repeat (LONG_LEN) begin
      e.read_base = pick_base();
      send_element(e);
    end
    e.cmd       = CMD_ALIGNED;
    e.opens_gap = 1'b0;
    repeat (TAIL_LEN) begin
      e.read_base = "A";
      e.ref_base  = "A";
      send_element(e);
    end
    repeat (TAIL_LEN) begin
      e.read_base = "C";
      e.ref_base  = "G";
      e.quality   = pick_quality();
      send_element(e);
    end
    e.cmd = CMD_DELETE;
    repeat (TAIL_LEN) begin
      e.ref_base = pick_base();
      send_element(e);
    end
    e.cmd = CMD_END;
    send_element(e);
  endtask

  initial begin
    cfg_t c;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_MM_MAX;
    cfg_wdata_i         <= '0;
    item_if.valid       <= 1'b0;
    item_if.cmd         <= CMD_ALIGNED;
    item_if.read_base   <= '0;
    item_if.ref_base    <= '0;
    item_if.quality     <= '0;
    item_if.opens_gap   <= 1'b0;
    pen = PEN_RESET;
    clear_read();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under the reset penalties
    add_row(CMD_END,     "A",   "A",   "I",   1'b0, 1'b1, 1'b1, KIND_TOTALS,    0, 0);
    add_row(CMD_ALIGNED, "A",   "A",   "I",   1'b0, 1'b1, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_ALIGNED, "A",   "C",   "I",   1'b0, 1'b1, 1'b1, KIND_MISMATCH,  1, "C");
    add_row(CMD_ALIGNED, "G",   "T",   8'h00, 1'b0, 1'b1, 1'b1, KIND_MISMATCH,  0, "T");
    add_row(CMD_ALIGNED, "N",   "A",   8'hFF, 1'b0, 1'b1, 1'b1, KIND_MISMATCH,  0, "A");
    add_row(CMD_ALIGNED, "A",   "N",   "!",   1'b0, 1'b1, 1'b1, KIND_MISMATCH,  0, "N");
    add_row(CMD_ALIGNED, "N",   "N",   "(",   1'b0, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_INSERT,  "G",   "A",   "2",   1'b1, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_INSERT,  "T",   "A",   "2",   1'b0, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_DELETE,  "A",   "G",   "I",   1'b1, 1'b1, 1'b1, KIND_DEL_START, 1, "G");
    add_row(CMD_DELETE,  "A",   "T",   "I",   1'b0, 1'b1, 1'b1, KIND_DEL_CONT,  0, "T");
    add_row(CMD_DELETE,  "A",   "A",   "I",   1'b1, 1'b1, 1'b1, KIND_DEL_START, 0, "A");
    add_row(CMD_ALIGNED, "C",   "C",   "I",   1'b0, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_DELETE,  "A",   "C",   "I",   1'b0, 1'b1, 1'b1, KIND_DEL_START, 1, "C");
    add_row(CMD_INSERT,  "A",   "A",   "I",   1'b0, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_DELETE,  8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b1, KIND_DEL_START, 0, 8'hFF);
    add_row(CMD_END,     8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_ALIGNED, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b1, KIND_MISMATCH,  0, 8'h00);
    add_row(CMD_ALIGNED, 8'h00, 8'hFF, "\"",  1'b1, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_ALIGNED, "T",   "T",   "J",   1'b0, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_ALIGNED, "T",   "G",   "J",   1'b0, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_INSERT,  8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    add_row(CMD_END,     8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_MISMATCH,  0, 0);
    directed_count = directed_rows.size();
    foreach (directed_rows[i]) send_element(directed_rows[i]);
    wait_drained();

    // random reads under four idling patterns and penalty settings
    for (int p = 0; p < 4; p++) begin
      c = '0;
      case (p)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 52;
          stall_pct = 0;
          c         = '1;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 52;
          c.mm_max  = CFG_W'($urandom_range(30));
          c.mm_min  = CFG_W'($urandom_range(63, 31));
        end
        default: begin
          gap_pct   = 24;
          stall_pct = 24;
          c.mm_max  = CFG_W'($urandom_range(63));
          c.mm_min  = CFG_W'($urandom_range(63));
        end
      endcase
      if (p >= 2) begin
        c.unknown     = CFG_W'($urandom_range(63));
        c.read_open   = CFG_W'($urandom_range(63));
        c.read_extend = CFG_W'($urandom_range(63));
        c.ref_open    = CFG_W'($urandom_range(63));
        c.ref_extend  = CFG_W'($urandom_range(63));
      end
      set_penalties(c);
      run_random(RAND_ITEMS);
    end

    // heaviest penalties on one very long read
    set_penalties('1);
    send_long_read();
    wait_drained();

    $display("sent %0d elements (%0d directed), checked %0d records", elems_sent,
             directed_count, records_seen);
    $display("penalties: reset, all zero, all max, min above max, random; %s",
             "long read hit the score floor and gap count ceilings");
    if (err_count == 0) begin
      $display("alignment_score_and_mismatch_tags test passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("alignment_score_and_mismatch_tags test failed");
    end
    $finish;
  end

endmodule
